// File: src/l2hs_pkg.sv
// shared types, constants and helpers for the log2 size histogram
package l2hs_pkg;

   localparam int NUM_BINS  = 24;
   localparam int BIN_IDX_W = $clog2(NUM_BINS);
   localparam int SIZE_W    = 32;
   localparam int ACC_W     = 64;
   localparam int MIN_W     = 25;
   localparam int IDX_W     = 5;
   localparam int LOG_W     = 5;

   localparam logic [MIN_W-1:0] MIN_BINNED_RESET = 25'd16;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   // shared adder operations
   localparam logic [2:0] ALU_NONE = 3'd0;
   localparam logic [2:0] ALU_GRP  = 3'd1;
   localparam logic [2:0] ALU_TSUM = 3'd2;
   localparam logic [2:0] ALU_TSQ  = 3'd3;
   localparam logic [2:0] ALU_BCNT = 3'd4;
   localparam logic [2:0] ALU_BSUM = 3'd5;
   localparam logic [2:0] ALU_BSQ  = 3'd6;

   typedef struct packed {
      logic [ACC_W-1:0] count;
      logic [ACC_W-1:0] sum;
      logic [ACC_W-1:0] sumsq;
   } l2hs_bin_type;

   typedef struct packed {
      logic [ACC_W-1:0]  groups;
      logic [ACC_W-1:0]  tsum;
      logic [ACC_W-1:0]  tsq;
      l2hs_bin_type      bin;
      logic [SIZE_W-1:0] size;
      logic              is_read;
   } l2hs_opnd_type;

   function automatic logic [LOG_W-1:0] floor_log2(input logic [SIZE_W-1:0] v);
      logic [LOG_W-1:0] k;
      k = '0;
      for (int i = 1; i < SIZE_W; i++) begin
         if (v[i]) begin
            k = LOG_W'(i);
         end
      end
      return k;
   endfunction

endpackage

// File: src/l2hs_arith.sv
// shared 64-bit accumulate adder with operand selection and a registered squarer
module l2hs_arith (
   input  logic                          clock,
   input  logic                          sq_en,
   input  logic [2:0]                    sel,
   input  l2hs_pkg::l2hs_opnd_type       opnd,
   output logic [l2hs_pkg::ACC_W-1:0]    result
);
   import l2hs_pkg::*;

   logic [ACC_W-1:0] sq_ff;
   logic [ACC_W-1:0] sq_in;
   logic [ACC_W-1:0] opa;
   logic [ACC_W-1:0] opb;
   logic [ACC_W-1:0] size_ext;

   assign size_ext = ACC_W'(opnd.size);
   assign sq_in    = size_ext * size_ext;

   always_ff @(posedge clock) begin
      if (sq_en) begin
         sq_ff <= sq_in;
      end
   end

   always_comb begin
      opa = '0;
      opb = '0;
      case (sel)
         ALU_GRP: begin
            opa = opnd.groups;
            opb = ACC_W'(1);
         end
         ALU_TSUM: begin
            opa = opnd.tsum;
            opb = size_ext;
         end
         ALU_TSQ: begin
            opa = opnd.tsq;
            opb = sq_ff;
         end
         ALU_BCNT: begin
            opa = opnd.bin.count;
            opb = opnd.is_read ? '0 : ACC_W'(1);
         end
         ALU_BSUM: begin
            opa = opnd.bin.sum;
            opb = opnd.is_read ? '0 : size_ext;
         end
         ALU_BSQ: begin
            opa = opnd.bin.sumsq;
            opb = opnd.is_read ? '0 : sq_ff;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign result = opa + opb;

endmodule

// File: src/l2hs_bin_mem.sv
// per-bin accumulator store with valid bits cleared by reset
module l2hs_bin_mem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [l2hs_pkg::BIN_IDX_W-1:0]    rd_addr,
   output l2hs_pkg::l2hs_bin_type            rd_data,
   input  logic                              wr_en,
   input  logic [l2hs_pkg::BIN_IDX_W-1:0]    wr_addr,
   input  l2hs_pkg::l2hs_bin_type            wr_data
);
   import l2hs_pkg::*;

   l2hs_bin_type        mem [NUM_BINS];
   logic [NUM_BINS-1:0] vld_ff;
   l2hs_bin_type        data_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? data_ff : '0;

endmodule

// File: src/log2_size_histogram_stats.sv
// top level: sequencer, running totals and result register of the size histogram
//
//  port group | direction | handshake          | payload
//  req_       | in        | req_valid/req_stall | operation, group_size, bin_index
//  rsp_       | out       | rsp_valid/rsp_stall | bin fields, totals, size_overflow
//  csr_       | in        | csr_valid/csr_ready | min_binned_size
//
//  each word passes from acceptance to the next acceptance through one pass of
//  the shared 64-bit adder for each of six accumulators, plus square, setup and
//  write-back steps
//  reset clears totals, bin valid bits and sets min_binned_size to 16
//  a word may be accepted while the previous result waits; a stalled result
//  holds the sequencer in its final step
module log2_size_histogram_stats (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [l2hs_pkg::SIZE_W-1:0]   req_group_size,
   input  logic [l2hs_pkg::IDX_W-1:0]    req_bin_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [l2hs_pkg::ACC_W-1:0]    rsp_bin_count,
   output logic [l2hs_pkg::ACC_W-1:0]    rsp_bin_sum,
   output logic [l2hs_pkg::ACC_W-1:0]    rsp_bin_sumsq,
   output logic [l2hs_pkg::ACC_W-1:0]    rsp_group_count,
   output logic [l2hs_pkg::SIZE_W-1:0]   rsp_largest_size,
   output logic [l2hs_pkg::ACC_W-1:0]    rsp_total_size,
   output logic [l2hs_pkg::ACC_W-1:0]    rsp_total_sq,
   output logic                          rsp_size_overflow,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [l2hs_pkg::MIN_W-1:0]    csr_min_binned_size
);
   import l2hs_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SQ   = 4'd1;
   localparam logic [3:0] ST_GRP  = 4'd2;
   localparam logic [3:0] ST_TSUM = 4'd3;
   localparam logic [3:0] ST_TSQ  = 4'd4;
   localparam logic [3:0] ST_BCNT = 4'd5;
   localparam logic [3:0] ST_BSUM = 4'd6;
   localparam logic [3:0] ST_BSQ  = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic                 op_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [MIN_W-1:0]     min_ff;
   logic                 hit_ff, hit_in;
   logic                 ovf_ff, ovf_in;
   logic                 use_bin_ff, use_bin_in;
   logic [BIN_IDX_W-1:0] addr_ff, addr_in;
   logic [ACC_W-1:0]     groups_ff, tsum_ff, tsq_ff;
   logic [SIZE_W-1:0]    largest_ff;
   logic [ACC_W-1:0]     bcnt_ff, bsum_ff, bsq_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 done_fire;
   logic                 push;
   logic [LOG_W-1:0]     log_k;
   logic                 binned;
   logic                 in_range;
   logic                 read_ok;
   logic [2:0]           alu_sel;
   logic [ACC_W-1:0]     alu_res;
   l2hs_opnd_type        opnd;
   l2hs_bin_type         rd_data;
   l2hs_bin_type         wr_data;
   logic                 wr_en;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign done_fire = (state_ff == ST_DONE) && out_free;
   assign push      = (op_ff == OP_PUSH);

   // bin classification
   assign log_k    = floor_log2(size_ff);
   assign binned   = size_ff >= SIZE_W'(min_ff);
   assign in_range = int'(log_k) < NUM_BINS;
   assign read_ok  = int'(idx_ff) < NUM_BINS;

   always_comb begin
      hit_in     = hit_ff;
      ovf_in     = ovf_ff;
      use_bin_in = use_bin_ff;
      addr_in    = addr_ff;
      if (state_ff == ST_SQ) begin
         hit_in     = push && binned && in_range;
         ovf_in     = push && binned && !in_range;
         use_bin_in = push ? (binned && in_range) : read_ok;
         if (push) begin
            addr_in = in_range ? BIN_IDX_W'(log_k) : '0;
         end else begin
            addr_in = read_ok ? BIN_IDX_W'(idx_ff) : '0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      alu_sel  = ALU_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_GRP;
         end
         ST_GRP: begin
            alu_sel  = ALU_GRP;
            state_in = ST_TSUM;
         end
         ST_TSUM: begin
            alu_sel  = ALU_TSUM;
            state_in = ST_TSQ;
         end
         ST_TSQ: begin
            alu_sel  = ALU_TSQ;
            state_in = ST_BCNT;
         end
         ST_BCNT: begin
            alu_sel  = ALU_BCNT;
            state_in = ST_BSUM;
         end
         ST_BSUM: begin
            alu_sel  = ALU_BSUM;
            state_in = ST_BSQ;
         end
         ST_BSQ: begin
            alu_sel  = ALU_BSQ;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = done_fire || (rsp_valid_ff && rsp_stall);

   assign opnd.groups  = groups_ff;
   assign opnd.tsum    = tsum_ff;
   assign opnd.tsq     = tsq_ff;
   assign opnd.bin     = rd_data;
   assign opnd.size    = size_ff;
   assign opnd.is_read = (op_ff == OP_READ);

   l2hs_arith u_arith (
      .clock  (clock),
      .sq_en  (state_ff == ST_SQ),
      .sel    (alu_sel),
      .opnd   (opnd),
      .result (alu_res)
   );

   assign wr_en         = done_fire && hit_ff;
   assign wr_data.count = bcnt_ff;
   assign wr_data.sum   = bsum_ff;
   assign wr_data.sumsq = bsq_ff;

   l2hs_bin_mem u_bin_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (state_ff == ST_GRP),
      .rd_addr (addr_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data)
   );

   // control and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_ff       <= MIN_BINNED_RESET;
         hit_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         use_bin_ff   <= 1'b0;
         addr_ff      <= '0;
         groups_ff    <= '0;
         tsum_ff      <= '0;
         tsq_ff       <= '0;
         largest_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         ovf_ff       <= ovf_in;
         use_bin_ff   <= use_bin_in;
         addr_ff      <= addr_in;
         if (csr_valid && csr_ready) begin
            min_ff <= csr_min_binned_size;
         end
         if (push) begin
            if (state_ff == ST_GRP) begin
               groups_ff <= alu_res;
               if (size_ff > largest_ff) begin
                  largest_ff <= size_ff;
               end
            end
            if (state_ff == ST_TSUM) begin
               tsum_ff <= alu_res;
            end
            if (state_ff == ST_TSQ) begin
               tsq_ff <= alu_res;
            end
         end
      end
   end

   // word capture, bin results and result register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_operation;
         size_ff <= req_group_size;
         idx_ff  <= req_bin_index;
      end
      if (state_ff == ST_BCNT) begin
         bcnt_ff <= use_bin_ff ? alu_res : '0;
      end
      if (state_ff == ST_BSUM) begin
         bsum_ff <= use_bin_ff ? alu_res : '0;
      end
      if (state_ff == ST_BSQ) begin
         bsq_ff <= use_bin_ff ? alu_res : '0;
      end
      if (done_fire) begin
         rsp_bin_count     <= bcnt_ff;
         rsp_bin_sum       <= bsum_ff;
         rsp_bin_sumsq     <= bsq_ff;
         rsp_group_count   <= groups_ff;
         rsp_largest_size  <= largest_ff;
         rsp_total_size    <= tsum_ff;
         rsp_total_sq      <= tsq_ff;
         rsp_size_overflow <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SQ))
      else $error("accepted word did not start the sequence");

   a_class_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({hit_ff, ovf_ff}))
      else $error("bin hit and overflow both set");

   a_ovf_no_bin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_size_overflow) |-> (rsp_bin_count == '0))
      else $error("overflowed size reported a bin count");

   a_write_last: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (state_ff == ST_IDLE))
      else $error("bin write outside the final step");

   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished word not presented");

endmodule
